/* rtl/core/arp1c_pkg.sv */
// Shared types and constants for the one-entry-cache ARP resolver.
// Used by arp1c_ctrl, arp1c_dp and the top level; depends on nothing.
package arp1c_pkg;

  localparam int unsigned REQ_LEN   = 42;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned FPOS_W    = 7;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned CFG_W     = 48;

  localparam logic [7:0] ETH_TYPE_HI = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO = 8'h06;

  localparam logic [3:0]  RETRY_RESET = 4'd3;
  localparam logic [15:0] POLL_RESET  = 16'd10000;

  // Bytes 12..21 of the request: type, htype, ptype, hlen, plen, opcode.
  localparam logic [7:0] HDR_FIXED [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };

  typedef enum logic [1:0] {
    CMD_RESOLVE = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_MAC  = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWN_MAC     = 2'd0,
    REG_OWN_IP      = 2'd1,
    REG_RETRY_LIMIT = 2'd2,
    REG_POLL_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_REQUEST,
    ACT_REPORT
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic take;
    logic tx_load;
    logic rep_load;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    tx_end;
    logic    slot_free;
  } dp_status_t;

endpackage

/* rtl/core/arp_resolver_one_entry_cache.sv */
// ARP resolver with a one-entry cache, top level.
// An item is registered in the controller state; its first result then goes
// into the output register. A 42-byte request runs one byte per cycle while
// out_ready drains the output register. Throughput: one item per cycle when no
// result follows; else the next item waits until its last output is loaded.
// Reset (synchronous): cache empty, idle, limits back to 3 and 10000.
module arp_resolver_one_entry_cache (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [arp1c_pkg::CFG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [arp1c_pkg::IP_W-1:0]  lookup_ip,
  input  logic [7:0]                  rx_byte,
  input  logic                        rx_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [7:0]                  tx_byte,
  output logic                        tx_last,
  output logic [arp1c_pkg::MAC_W-1:0] resolved_mac
);
  import arp1c_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  arp1c_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  arp1c_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .lookup_ip    (lookup_ip),
    .rx_byte      (rx_byte),
    .rx_last      (rx_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .tx_byte      (tx_byte),
    .tx_last      (tx_last),
    .resolved_mac (resolved_mac)
  );

endmodule

/* rtl/core/arp1c_ctrl.sv */
// Controller for the ARP resolver: takes items, sequences request bursts
// and single reports. Depends on arp1c_pkg.
module arp1c_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arp1c_pkg::dp_status_t status,
  output arp1c_pkg::dp_cmd_t    cmd
);
  import arp1c_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.tx_load  = 1'b0;
    cmd.rep_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.action == ACT_REQUEST) state_next = ST_TX;
          else if (status.action == ACT_REPORT) state_next = ST_REPORT;
        end
      end
      ST_TX: begin
        // one request byte per free output slot
        if (status.slot_free) begin
          cmd.tx_load = 1'b1;
          if (status.tx_end) state_next = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (status.slot_free) begin
          cmd.rep_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/arp1c_dp.sv */
// Datapath for the ARP resolver: config registers, cache, retry state,
// receive frame tracking, request byte generator and output register.
// Depends on arp1c_pkg.
module arp1c_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  arp1c_pkg::dp_cmd_t               cmd,
  output arp1c_pkg::dp_status_t            status,
  input  logic                             cfg_valid,
  input  logic [1:0]                       cfg_index,
  input  logic [arp1c_pkg::CFG_W-1:0]      cfg_data,
  input  logic [1:0]                       command,
  input  logic [arp1c_pkg::IP_W-1:0]       lookup_ip,
  input  logic [7:0]                       rx_byte,
  input  logic                             rx_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       kind,
  output logic [7:0]                       tx_byte,
  output logic                             tx_last,
  output logic [arp1c_pkg::MAC_W-1:0]      resolved_mac
);
  import arp1c_pkg::*;

  // configuration
  logic [MAC_W-1:0] own_mac;
  logic [IP_W-1:0]  own_ip;
  logic [3:0]       retry_limit;
  logic [15:0]      poll_limit;

  // resolver state
  logic [IP_W-1:0]   cached_ip, cached_ip_next;
  logic [MAC_W-1:0]  cached_mac, cached_mac_next;
  logic              cache_full, cache_full_next;
  logic [IP_W-1:0]   pending_ip, pending_ip_next;
  logic              busy, busy_next;
  logic [3:0]        sends_done, sends_done_next;
  logic [15:0]       polls_done, polls_done_next;
  logic [FPOS_W-1:0] frame_pos, frame_pos_next;
  logic              frame_ok, frame_ok_next;
  logic [MAC_W-1:0]  captured_mac, captured_mac_next;

  // pending report
  kind_t             rep_kind, rep_kind_next;
  logic [MAC_W-1:0]  rep_mac, rep_mac_next;

  logic [POS_W-1:0]  tx_pos;
  logic [7:0]        req_byte;
  logic [2:0]        mac_sel;
  logic [1:0]        ip_sel;
  logic [1:0]        rx_ip_sel;
  logic [7:0]        rx_ip_byte;
  logic [15:0]       polls_inc;
  logic              do_poll;
  logic              is_match;
  action_t           action;

  // -------- configuration writes --------
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac     <= '0;
      own_ip      <= '0;
      retry_limit <= RETRY_RESET;
      poll_limit  <= POLL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OWN_MAC:     own_mac     <= cfg_data[MAC_W-1:0];
        REG_OWN_IP:      own_ip      <= cfg_data[IP_W-1:0];
        REG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        REG_POLL_LIMIT:  poll_limit  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // -------- item processing --------
  assign rx_ip_sel  = 2'(2'd3 - frame_pos[1:0]);
  assign rx_ip_byte = 8'(pending_ip >> {rx_ip_sel, 3'b000});
  assign polls_inc  = (polls_done != 16'hFFFF) ? 16'(polls_done + 16'd1) : polls_done;

  always_comb begin
    cached_ip_next    = cached_ip;
    cached_mac_next   = cached_mac;
    cache_full_next   = cache_full;
    pending_ip_next   = pending_ip;
    busy_next         = busy;
    sends_done_next   = sends_done;
    polls_done_next   = polls_done;
    frame_pos_next    = frame_pos;
    frame_ok_next     = frame_ok;
    captured_mac_next = captured_mac;
    rep_kind_next     = rep_kind;
    rep_mac_next      = rep_mac;
    action            = ACT_NONE;
    do_poll           = 1'b0;
    is_match          = 1'b0;

    case (command_t'(command))
      CMD_RESOLVE: begin
        if (!busy) begin
          if (cache_full && cached_ip == lookup_ip) begin
            action        = ACT_REPORT;
            rep_kind_next = KIND_MAC;
            rep_mac_next  = cached_mac;
          end else begin
            pending_ip_next = lookup_ip;
            busy_next       = 1'b1;
            sends_done_next = 4'd1;
            polls_done_next = '0;
            action          = ACT_REQUEST;
          end
        end
      end
      CMD_RX_BYTE: begin
        if (frame_pos == FPOS_W'(12) && rx_byte != ETH_TYPE_HI) frame_ok_next = 1'b0;
        if (frame_pos == FPOS_W'(13) && rx_byte != ETH_TYPE_LO) frame_ok_next = 1'b0;
        if (frame_pos >= FPOS_W'(22) && frame_pos < FPOS_W'(28))
          captured_mac_next = {captured_mac[MAC_W-9:0], rx_byte};
        if (frame_pos >= FPOS_W'(28) && frame_pos < FPOS_W'(32) && rx_byte != rx_ip_byte)
          frame_ok_next = 1'b0;
        if (frame_pos != '1) frame_pos_next = FPOS_W'(frame_pos + 1'b1);
        if (rx_last) begin
          is_match       = frame_ok_next && (frame_pos >= FPOS_W'(REQ_LEN - 1));
          frame_pos_next = '0;
          frame_ok_next  = 1'b1;
          if (busy) begin
            if (is_match) begin
              cached_ip_next  = pending_ip;
              cached_mac_next = captured_mac_next;
              cache_full_next = 1'b1;
              busy_next       = 1'b0;
              action          = ACT_REPORT;
              rep_kind_next   = KIND_MAC;
              rep_mac_next    = captured_mac_next;
            end else begin
              do_poll = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (busy) do_poll = 1'b1;
      end
      default: ;
    endcase

    // poll counted while waiting: resend or give up on expiry
    if (do_poll) begin
      polls_done_next = polls_inc;
      if (polls_inc >= poll_limit) begin
        if (sends_done >= retry_limit) begin
          busy_next     = 1'b0;
          action        = ACT_REPORT;
          rep_kind_next = KIND_FAIL;
          rep_mac_next  = '0;
        end else begin
          sends_done_next = 4'(sends_done + 4'd1);
          polls_done_next = '0;
          action          = ACT_REQUEST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_ip    <= '0;
      cached_mac   <= '0;
      cache_full   <= 1'b0;
      pending_ip   <= '0;
      busy         <= 1'b0;
      sends_done   <= '0;
      polls_done   <= '0;
      frame_pos    <= '0;
      frame_ok     <= 1'b1;
      captured_mac <= '0;
      rep_kind     <= KIND_MAC;
      rep_mac      <= '0;
    end else if (cmd.take) begin
      cached_ip    <= cached_ip_next;
      cached_mac   <= cached_mac_next;
      cache_full   <= cache_full_next;
      pending_ip   <= pending_ip_next;
      busy         <= busy_next;
      sends_done   <= sends_done_next;
      polls_done   <= polls_done_next;
      frame_pos    <= frame_pos_next;
      frame_ok     <= frame_ok_next;
      captured_mac <= captured_mac_next;
      rep_kind     <= rep_kind_next;
      rep_mac      <= rep_mac_next;
    end
  end

  // -------- request byte generator --------
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_pos <= '0;
    end else if (cmd.take) begin
      tx_pos <= '0;
    end else if (cmd.tx_load) begin
      tx_pos <= POS_W'(tx_pos + 1'b1);
    end
  end

  always_comb begin
    mac_sel = (tx_pos < POS_W'(12)) ? 3'(POS_W'(11) - tx_pos) : 3'(POS_W'(27) - tx_pos);
    ip_sel  = (tx_pos < POS_W'(32)) ? 2'(POS_W'(31) - tx_pos) : 2'(POS_W'(41) - tx_pos);
    if (tx_pos < POS_W'(6))       req_byte = 8'hFF;
    else if (tx_pos < POS_W'(12)) req_byte = 8'(own_mac >> {mac_sel, 3'b000});
    else if (tx_pos < POS_W'(22)) req_byte = HDR_FIXED[4'(tx_pos - POS_W'(12))];
    else if (tx_pos < POS_W'(28)) req_byte = 8'(own_mac >> {mac_sel, 3'b000});
    else if (tx_pos < POS_W'(32)) req_byte = 8'(own_ip >> {ip_sel, 3'b000});
    else if (tx_pos < POS_W'(38)) req_byte = 8'h00;
    else                          req_byte = 8'(pending_ip >> {ip_sel, 3'b000});
  end

  // -------- output register --------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tx_load || cmd.rep_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tx_load) begin
      kind         <= KIND_TX;
      tx_byte      <= req_byte;
      tx_last      <= (tx_pos == POS_W'(REQ_LEN - 1));
      resolved_mac <= '0;
    end else if (cmd.rep_load) begin
      kind         <= rep_kind;
      tx_byte      <= '0;
      tx_last      <= 1'b0;
      resolved_mac <= rep_mac;
    end
  end

  assign status.action    = action;
  assign status.tx_end    = (tx_pos == POS_W'(REQ_LEN - 1));
  assign status.slot_free = !out_valid || out_ready;

endmodule
